// File: rtl/planar_blit_setup_assert.svh
// assertion helpers for the planar blit setup block
// both expect clk and rst_n in scope
`ifndef PLANAR_BLIT_SETUP_ASSERT_SVH
`define PLANAR_BLIT_SETUP_ASSERT_SVH

// consequent checked in the same cycle
`define PBS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define PBS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/pbs_pkg.sv
`default_nettype none

package pbs_pkg;

  localparam logic [7:0] FLAG_NFSR = 8'h40;
  localparam logic [7:0] FLAG_FXSR = 8'h80;
  localparam logic [15:0] MASK_ALL = 16'hFFFF;

  localparam logic [14:0] SRC_ROW_RESET  = 15'd160;
  localparam logic [14:0] DST_ROW_RESET  = 15'd160;
  localparam logic [4:0]  SRC_STEP_RESET = 5'd8;
  localparam logic [4:0]  DST_STEP_RESET = 5'd8;

  // index bits: {single word, equal word counts, src phase above dst phase}
  localparam logic [7:0] SKEW_FLAGS [8] = '{
    FLAG_NFSR, FLAG_FXSR, 8'h00, FLAG_NFSR | FLAG_FXSR,
    8'h00, FLAG_FXSR, 8'h00, 8'h00
  };

  typedef enum logic [1:0] {
    REG_SRC_PITCH     = 2'd0,
    REG_DST_PITCH     = 2'd1,
    REG_SRC_WORD_STEP = 2'd2,
    REG_DST_WORD_STEP = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [14:0] src_pitch;
    logic [14:0] dst_pitch;
    logic [4:0]  src_word_step;
    logic [4:0]  dst_word_step;
  } cfg_regs_t;

  // last field in the lowest bits
  typedef struct packed {
    logic [4:0]  pad;
    logic        flip_y;
    logic        flip_x;
    logic [14:0] height;
    logic [11:0] width;
    logic [14:0] dst_x;
    logic [14:0] src_x;
    logic [31:0] dst_addr;
    logic [31:0] src_addr;
  } in_item_t;

  typedef struct packed {
    logic [31:0]        dst_start;
    logic [31:0]        src_start;
    logic [7:0]         skew_bits;
    logic [15:0]        word_count;
    logic [15:0]        mask_last;
    logic [15:0]        mask_middle;
    logic [15:0]        mask_first;
    logic signed [15:0] dst_y_step;
    logic signed [15:0] dst_x_step;
    logic signed [15:0] src_y_step;
    logic signed [15:0] src_x_step;
  } out_data_t;

  typedef struct packed {
    logic      ok;
    out_data_t data;
  } out_res_t;

endpackage

`default_nettype wire

// File: rtl/pbs_calc.sv
`default_nettype none

module pbs_calc (
  input  var pbs_pkg::in_item_t  req,
  input  var pbs_pkg::cfg_regs_t cfg,
  output pbs_pkg::out_res_t      res
);

  logic [15:0] s_end, d_end;
  logic [11:0] sw_diff, dw_diff;
  logic [8:0]  sw_m1, dw_m1;
  logic [3:0]  sm, dm, shift;
  logic        single, same_cnt, zero_x, ok, rx, ry;
  logic [2:0]  idx;
  logic [15:0] m1, m3, m13;
  logic [13:0] s_wprod, d_wprod;
  logic [14:0] h_m1;
  logic [29:0] s_rprod, d_rprod;
  logic [15:0] s_step, d_step, s_xc, d_xc, s_row, d_row;
  logic [31:0] s_yoff, d_yoff, s_xoff, d_xoff;
  pbs_pkg::out_data_t d;

  assign rx = req.flip_x;
  assign ry = req.flip_y;
  assign ok = (req.width != 12'd0) && (req.height != 15'd0) &&
              (req.src_addr != 32'd0) && (req.dst_addr != 32'd0);

  // last pixel column of the line, then words spanned minus one
  assign s_end   = {1'b0, req.src_x} + {4'd0, req.width} - 16'd1;
  assign d_end   = {1'b0, req.dst_x} + {4'd0, req.width} - 16'd1;
  assign sw_diff = s_end[15:4] - {1'b0, req.src_x[14:4]};
  assign dw_diff = d_end[15:4] - {1'b0, req.dst_x[14:4]};
  assign sw_m1   = sw_diff[8:0];
  assign dw_m1   = dw_diff[8:0];

  assign sm       = req.src_x[3:0];
  assign dm       = req.dst_x[3:0];
  assign shift    = dm - sm;
  assign single   = (dw_m1 == 9'd0);
  assign same_cnt = (sw_m1 == dw_m1);
  assign idx      = {single, same_cnt, sm > dm} ^ {2'b00, rx && (sm != dm)};
  assign zero_x   = single && (sw_m1 == 9'd0) && (shift != 4'd0);

  assign m1  = pbs_pkg::MASK_ALL >> dm;
  assign m3  = pbs_pkg::MASK_ALL << (4'd15 - d_end[3:0]);
  assign m13 = m1 & m3;

  assign s_wprod = {5'd0, sw_m1} * {9'd0, cfg.src_word_step};
  assign d_wprod = {5'd0, dw_m1} * {9'd0, cfg.dst_word_step};
  assign h_m1    = req.height - 15'd1;
  assign s_rprod = {15'd0, h_m1} * {15'd0, cfg.src_pitch};
  assign d_rprod = {15'd0, h_m1} * {15'd0, cfg.dst_pitch};

  assign s_step = rx ? 16'd0 - {11'd0, cfg.src_word_step} : {11'd0, cfg.src_word_step};
  assign d_step = rx ? 16'd0 - {11'd0, cfg.dst_word_step} : {11'd0, cfg.dst_word_step};
  // word walk contribution removed from the row stride
  assign s_xc = zero_x ? 16'd0 : (rx ? 16'd0 - {2'd0, s_wprod} : {2'd0, s_wprod});
  assign d_xc = zero_x ? 16'd0 : (rx ? 16'd0 - {2'd0, d_wprod} : {2'd0, d_wprod});
  assign s_row = ry ? 16'd0 - {1'b0, cfg.src_pitch} : {1'b0, cfg.src_pitch};
  assign d_row = ry ? 16'd0 - {1'b0, cfg.dst_pitch} : {1'b0, cfg.dst_pitch};

  assign s_yoff = ry ? {2'd0, s_rprod} : 32'd0;
  assign d_yoff = ry ? {2'd0, d_rprod} : 32'd0;
  assign s_xoff = rx ? {18'd0, s_wprod} : 32'd0;
  assign d_xoff = rx ? {18'd0, d_wprod} : 32'd0;

  always_comb begin
    d.src_x_step  = zero_x ? 16'sd0 : $signed(s_step);
    d.dst_x_step  = zero_x ? 16'sd0 : $signed(d_step);
    d.src_y_step  = $signed(s_row - s_xc);
    d.dst_y_step  = $signed(d_row - d_xc);
    d.mask_first  = single ? m13 : (rx ? m3 : m1);
    d.mask_last   = single ? m13 : (rx ? m1 : m3);
    d.mask_middle = single ? m13 : pbs_pkg::MASK_ALL;
    d.word_count  = {7'd0, dw_m1} + 16'd1;
    d.skew_bits   = zero_x ? (pbs_pkg::FLAG_FXSR | {4'd0, shift})
                           : (pbs_pkg::SKEW_FLAGS[idx] | {4'd0, shift});
    d.src_start   = req.src_addr + s_yoff + s_xoff;
    d.dst_start   = req.dst_addr + d_yoff + d_xoff;
    res.ok   = ok;
    res.data = ok ? d : '0;
  end

endmodule

`default_nettype wire

// File: rtl/planar_blit_setup.sv
`default_nettype none

// Planar blit setup: turns one rectangle blit request into the register image of a
// 16-bit-word bitplane blitter (x/y steps, end masks, word count, skew, start
// addresses). One request is taken every clock while the result side is not
// backpressured; each request is registered in the input register and then in the
// result register, with the setup arithmetic in between. Backpressure on the
// result side holds both registers; the input is ready whenever the input register
// is empty or the result register can take the next image. Strides and word steps
// are written through the cfg channel, which is always ready; write them only while
// no request is in flight.
module planar_blit_setup (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // cfg
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [1:0]   cfg_addr,
  input  wire logic [14:0]  cfg_data,
  // request stream
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // src_addr[31:0], dst_addr[63:32], src_x[78:64], dst_x[93:79], width[105:94],
  // height[120:106], flip_x[121], flip_y[122], zero[127:123]
  input  wire logic [127:0] in_tdata,
  // result stream
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // src_x_step[15:0], src_y_step[31:16], dst_x_step[47:32], dst_y_step[63:48],
  // mask_first[79:64], mask_middle[95:80], mask_last[111:96], word_count[127:112],
  // skew_bits[135:128], src_start[167:136], dst_start[199:168]
  output logic [199:0]      out_tdata,
  // ok[0]
  output logic              out_tuser
);

  pbs_pkg::cfg_regs_t cfg_r, cfg_nxt;
  pbs_pkg::in_item_t  req_r, req_nxt;
  pbs_pkg::out_res_t  res_r, res_nxt, calc_res;
  logic               req_valid_r, req_valid_nxt;
  logic               res_valid_r, res_valid_nxt;
  logic               res_free, req_adv, in_xact;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (pbs_pkg::cfg_reg_t'(cfg_addr))
        pbs_pkg::REG_SRC_PITCH:     cfg_nxt.src_pitch     = cfg_data;
        pbs_pkg::REG_DST_PITCH:     cfg_nxt.dst_pitch     = cfg_data;
        pbs_pkg::REG_SRC_WORD_STEP: cfg_nxt.src_word_step = cfg_data[4:0];
        pbs_pkg::REG_DST_WORD_STEP: cfg_nxt.dst_word_step = cfg_data[4:0];
      endcase
    end
  end

  assign res_free  = !res_valid_r || out_tready;
  assign req_adv   = req_valid_r && res_free;
  assign in_tready = !req_valid_r || res_free;
  assign in_xact   = in_tvalid && in_tready;

  always_comb begin
    req_nxt       = req_r;
    req_valid_nxt = req_valid_r;
    if (in_xact) begin
      req_nxt       = pbs_pkg::in_item_t'(in_tdata);
      req_valid_nxt = 1'b1;
    end else if (req_adv) begin
      req_valid_nxt = 1'b0;
    end
  end

  pbs_calc u_calc (
    .req (req_r),
    .cfg (cfg_r),
    .res (calc_res)
  );

  always_comb begin
    res_nxt       = res_r;
    res_valid_nxt = res_valid_r;
    if (req_adv) begin
      res_nxt       = calc_res;
      res_valid_nxt = 1'b1;
    end else if (out_tready) begin
      res_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.src_pitch     <= pbs_pkg::SRC_ROW_RESET;
      cfg_r.dst_pitch     <= pbs_pkg::DST_ROW_RESET;
      cfg_r.src_word_step <= pbs_pkg::SRC_STEP_RESET;
      cfg_r.dst_word_step <= pbs_pkg::DST_STEP_RESET;
      req_valid_r         <= 1'b0;
      res_valid_r         <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      req_valid_r <= req_valid_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt;
    res_r <= res_nxt;
  end

  assign out_tvalid = res_valid_r;
  assign out_tdata  = res_r.data;
  assign out_tuser  = res_r.ok;

`include "planar_blit_setup_assert.svh"

  `PBS_ASSERT_NOW(a_reject_zero, res_valid_r && !res_r.ok, res_r.data == '0,
    "rejected request carries nonzero register image")
  `PBS_ASSERT_NOW(a_mask_single,
    res_valid_r && res_r.ok && (res_r.data.mask_middle != pbs_pkg::MASK_ALL),
    (res_r.data.mask_first == res_r.data.mask_middle) &&
    (res_r.data.mask_last == res_r.data.mask_middle),
    "single word masks differ")
  `PBS_ASSERT_NOW(a_single_count,
    res_valid_r && res_r.ok && (res_r.data.word_count != 16'd1),
    res_r.data.mask_middle == pbs_pkg::MASK_ALL,
    "multi word line without full middle mask")
  `PBS_ASSERT_NEXT(a_req_loaded, in_xact, req_valid_r,
    "accepted request not held in input register")

endmodule

`default_nettype wire
